/* hdl/prt_pkg.sv */
// Shared types, field widths and codes for the prescaled reference timer.
package prt_pkg;

    localparam int COUNTER_BITS_DEF = 16;

    localparam int CYC_W      = 16;
    localparam int FRAC_W     = 12;
    localparam int SUM_W      = CYC_W + 1;
    localparam int PRE_W      = 8;
    localparam int DIVR_W     = 13;
    localparam int REF_W      = 16;
    localparam int PER_W      = REF_W + 1;
    localparam int OUT_CNT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SOURCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_IRQ_ENABLE = 3'd5;

    localparam logic [1:0] KIND_ADVANCE    = 2'd0;
    localparam logic [1:0] KIND_COUNTER_WR = 2'd1;
    localparam logic [1:0] KIND_EVENT_WR   = 2'd2;

    localparam logic [1:0] SRC_SYS       = 2'd1;
    localparam logic [1:0] SRC_SYS_DIV16 = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CYC_W-1:0] cycles_elapsed;
        logic             clear_ref;
    } t_in;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] counter_value;
        logic                 ref_event;
        logic                 irq_request;
    } t_out;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_sel_mod;
        logic upd_simple;
        logic upd_frac;
        logic upd_total;
        logic upd_mod;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic needs_div;
        logic mod_needed;
        logic div_done;
    } t_dp_sts;

endpackage

/* hdl/prescaled_reference_timer_unit.sv */
// Top level of the prescaled reference timer: controller, datapath and ports.
//
//   channel | direction | handshake                  | beat
//   --------+-----------+----------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in (kind, cycles, clear)
//   out     | output    | o_out_valid / i_out_ready  | o_out (counter, event, irq)
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item at a time. An item that needs no tick math goes from the decode state
// straight to the result. An advance that yields ticks runs the shared bit-serial
// divider, of width DW = max(COUNTER_BITS, 17) + 1, and a restart-mode wrap runs
// it a second time for the modulo.
// Reset is synchronous and clears control state, configuration and counter.
// A stalled result beat waits in the output register; configuration is always ready.
module prescaled_reference_timer_unit #(
    parameter int COUNTER_BITS = prt_pkg::COUNTER_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  prt_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output prt_pkg::t_out                  o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [prt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import prt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    prt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    prt_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out)
    );

    assign o_cfg_ready = 1'b1;

endmodule

/* hdl/prt_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module prt_div #(
    parameter int DW = 18,
    parameter int VW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_dvs;
    logic [VW:0]      shifted;
    logic [VW:0]      diff;
    logic             fits;

    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        diff    = shifted - {1'b0, r_dvs};
        fits    = shifted >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The partial remainder always stays below the divisor, so VW bits hold it.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? diff[VW-1:0] : shifted[VW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

/* hdl/prt_dp.sv */
// Datapath: configuration registers, counter state, divider and result register.
module prt_dp #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [prt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  prt_pkg::t_in                   i_in,
    input  prt_pkg::t_dp_cmd               i_cmd,
    output prt_pkg::t_dp_sts               o_sts,
    output prt_pkg::t_out                  o_out
);

    import prt_pkg::*;

    localparam int TOT_W = ((COUNTER_BITS > SUM_W) ? COUNTER_BITS : SUM_W) + 1;
    localparam int AW    = TOT_W + 1;
    localparam int EXT_W = (COUNTER_BITS > OUT_CNT_W) ? COUNTER_BITS : OUT_CNT_W;

    logic             r_timer_enable;
    logic [1:0]       r_clock_source;
    logic [PRE_W-1:0] r_prescale;
    logic [REF_W-1:0] r_reference_value;
    logic             r_restart;
    logic             r_irq_enable;

    logic [1:0]              r_kind;
    logic [CYC_W-1:0]        r_cycles;
    logic                    r_clear;
    logic [COUNTER_BITS-1:0] r_count;
    logic [FRAC_W-1:0]       r_frac;
    logic                    r_ref;
    logic [SUM_W-1:0]        r_ticks;
    t_out                    r_out;

    logic             running;
    logic [PRE_W:0]   pre_inc;
    logic [DIVR_W-1:0] divr;
    logic [SUM_W-1:0] sum;
    logic [TOT_W-1:0] total;
    logic [PER_W-1:0] period;
    logic             wrap;
    logic [AW-1:0]    mod_val;
    logic [AW-1:0]    ref_mod;
    logic [AW-1:0]    a_pos;
    logic [AW-1:0]    b_pos;
    logic             free_hit;
    logic [TOT_W-1:0] div_dividend;
    logic [PER_W-1:0] div_divisor;
    logic             div_done;
    logic [TOT_W-1:0] div_quot;
    logic [PER_W-1:0] div_rem;
    logic [TOT_W-1:0] rem_ext;
    logic [EXT_W-1:0] cnt_ext;

    always_comb begin
        running = r_timer_enable &&
                  (r_clock_source == SRC_SYS || r_clock_source == SRC_SYS_DIV16);
        pre_inc = {1'b0, r_prescale} + (PRE_W + 1)'(1);
        divr    = (r_clock_source == SRC_SYS_DIV16) ? {pre_inc, 4'b0000}
                                                     : DIVR_W'(pre_inc);
        sum     = SUM_W'(r_cycles) + SUM_W'(r_frac);
        total   = TOT_W'(r_count) + TOT_W'(r_ticks);
        period  = PER_W'(r_reference_value) + PER_W'(1);
        wrap    = total >= TOT_W'(period);

        // Free-running match: the count crossed a value congruent to the reference
        // when the offset positions fall in different wraps of the counter.
        mod_val  = AW'(1) << COUNTER_BITS;
        ref_mod  = AW'(r_reference_value) & (mod_val - AW'(1));
        a_pos    = AW'(total) + mod_val - ref_mod;
        b_pos    = AW'(r_count) + mod_val - ref_mod;
        free_hit = a_pos[AW-1:COUNTER_BITS] != b_pos[AW-1:COUNTER_BITS];

        div_dividend = i_cmd.div_sel_mod ? total : TOT_W'(sum);
        div_divisor  = i_cmd.div_sel_mod ? period : PER_W'(divr);
        rem_ext      = TOT_W'(div_rem);
        cnt_ext      = EXT_W'(r_count);
    end

    prt_div #(
        .DW (TOT_W),
        .VW (PER_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_enable    <= 1'b0;
            r_clock_source    <= '0;
            r_prescale        <= '0;
            r_reference_value <= '0;
            r_restart         <= 1'b0;
            r_irq_enable      <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMER_ENABLE:   r_timer_enable    <= i_cfg_data[0];
                CFG_CLOCK_SOURCE:   r_clock_source    <= i_cfg_data[1:0];
                CFG_PRESCALE:       r_prescale        <= i_cfg_data[PRE_W-1:0];
                CFG_REFERENCE:      r_reference_value <= i_cfg_data[REF_W-1:0];
                CFG_RESTART:        r_restart         <= i_cfg_data[0];
                CFG_REF_IRQ_ENABLE: r_irq_enable      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_frac  <= '0;
            r_ref   <= 1'b0;
        end else begin
            if (i_cmd.upd_simple) begin
                case (r_kind)
                    KIND_ADVANCE: begin
                        // Not enough cycles for a whole tick: only the fraction grows.
                        if (running) begin
                            r_frac <= sum[FRAC_W-1:0];
                        end
                    end
                    KIND_COUNTER_WR: begin
                        r_count <= '0;
                        r_frac  <= '0;
                    end
                    KIND_EVENT_WR: begin
                        if (r_clear) begin
                            r_ref <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.upd_frac) begin
                r_frac <= div_rem[FRAC_W-1:0];
            end
            if (i_cmd.upd_total) begin
                if (r_restart) begin
                    // On a wrap the count is set after the modulo pass.
                    if (wrap) begin
                        r_ref <= 1'b1;
                    end else begin
                        r_count <= total[COUNTER_BITS-1:0];
                    end
                end else begin
                    r_count <= total[COUNTER_BITS-1:0];
                    if (free_hit) begin
                        r_ref <= 1'b1;
                    end
                end
            end
            if (i_cmd.upd_mod) begin
                r_count <= rem_ext[COUNTER_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_in.kind;
            r_cycles <= i_in.cycles_elapsed;
            r_clear  <= i_in.clear_ref;
        end
        if (i_cmd.upd_frac) begin
            r_ticks <= div_quot[SUM_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out.counter_value <= cnt_ext[OUT_CNT_W-1:0];
            r_out.ref_event     <= r_ref;
            r_out.irq_request   <= r_ref & r_irq_enable;
        end
    end

    assign o_sts.needs_div  = (r_kind == KIND_ADVANCE) && running &&
                              (sum >= SUM_W'(divr));
    assign o_sts.mod_needed = r_restart && wrap;
    assign o_sts.div_done   = div_done;
    assign o_out            = r_out;

endmodule

/* hdl/prt_ctrl.sv */
// Controller state machine that sequences one item through the datapath.
module prt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  prt_pkg::t_dp_sts  i_sts,
    output prt_pkg::t_dp_cmd  o_cmd
);

    import prt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIVF,
        ST_CMP,
        ST_DIVM,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_sts.needs_div) begin
                    cmd.div_start = 1'b1;
                    n_state       = ST_DIVF;
                end else begin
                    cmd.upd_simple = 1'b1;
                    n_state        = ST_FIN;
                end
            end
            ST_DIVF: begin
                if (i_sts.div_done) begin
                    cmd.upd_frac = 1'b1;
                    n_state      = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.upd_total = 1'b1;
                if (i_sts.mod_needed) begin
                    cmd.div_start   = 1'b1;
                    cmd.div_sel_mod = 1'b1;
                    n_state         = ST_DIVM;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIVM: begin
                if (i_sts.div_done) begin
                    cmd.upd_mod = 1'b1;
                    n_state     = ST_FIN;
                end
            end
            ST_FIN: begin
                // The result register may still hold the previous beat.
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

/* sim/timer_reading_checker.sv */
// Checker for the prescaled reference timer: predicts every result beat and compares it.
module timer_reading_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  prt_pkg::t_in                   i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  prt_pkg::t_out                  i_out,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [prt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_matches
);
    import prt_pkg::*;

    // Register copies, tracked from the configuration beats.
    logic        timer_on;
    logic [1:0]  clk_src;
    logic [7:0]  prescale_q;
    logic [15:0] compare_q;
    logic        restart_q;
    logic        irq_en_q;

    // Timer state.
    logic [15:0]     count_q;
    longint unsigned frac_q;
    logic            event_q;

    prt_pkg::t_out expected_readings[$];

    int error_count = 0;
    int pending_count = 0;
    int checked_count = 0;
    int match_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;
    assign o_checked = checked_count;
    assign o_matches = match_count;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < 100) begin
            $display("[%0t] mismatch on result %0d: %s is %0h, predicted %0h",
                     $realtime, checked_count, what, got, want);
        end
        error_count++;
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] index,
                                 input logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_TIMER_ENABLE:   timer_on   = data[0];
            CFG_CLOCK_SOURCE:   clk_src    = data[1:0];
            CFG_PRESCALE:       prescale_q = data[7:0];
            CFG_REFERENCE:      compare_q  = data[15:0];
            CFG_RESTART:        restart_q  = data[0];
            CFG_REF_IRQ_ENABLE: irq_en_q   = data[0];
            default: ;
        endcase
    endtask

    function automatic void advance_timer(input logic [15:0] cycles);
        longint unsigned divisor, ticks, start, total, period, wrap, target;
        logic hit;
        if (!timer_on || !(clk_src == SRC_SYS || clk_src == SRC_SYS_DIV16)) return;
        divisor = (longint'(prescale_q) + 1) * ((clk_src == SRC_SYS_DIV16) ? 16 : 1);
        frac_q += cycles;
        if (frac_q < divisor) return;
        ticks = frac_q / divisor;
        frac_q -= ticks * divisor;
        start = count_q;
        total = start + ticks;
        if (restart_q) begin
            period = longint'(compare_q) + 1;
            hit = total >= period;
            if (hit) total = total % period;
        end else begin
            // A match is any step that crosses a value congruent to the reference.
            wrap = 64'h10000;
            target = compare_q;
            hit = ((total + wrap - target) / wrap) != ((start + wrap - target) / wrap);
        end
        count_q = total[15:0];
        if (hit) begin
            event_q = 1'b1;
            match_count++;
        end
    endfunction

    function automatic prt_pkg::t_out predict_timer_step(input prt_pkg::t_in beat);
        prt_pkg::t_out reading;
        case (beat.kind)
            KIND_ADVANCE: advance_timer(beat.cycles_elapsed);
            KIND_COUNTER_WR: begin
                count_q = '0;
                frac_q = 0;
            end
            KIND_EVENT_WR: if (beat.clear_ref) event_q = 1'b0;
            default: ;
        endcase
        reading.counter_value = count_q;
        reading.ref_event = event_q;
        reading.irq_request = event_q & irq_en_q;
        return reading;
    endfunction

    task automatic check_reading(input prt_pkg::t_out got);
        prt_pkg::t_out want;
        if (expected_readings.size() == 0) begin
            report_mismatch("result beat with no item pending, counter", got.counter_value, 0);
            return;
        end
        want = expected_readings.pop_front();
        if (got.counter_value !== want.counter_value)
            report_mismatch("counter_value", got.counter_value, want.counter_value);
        if (got.ref_event !== want.ref_event)
            report_mismatch("ref_event", got.ref_event, want.ref_event);
        if (got.irq_request !== want.irq_request)
            report_mismatch("irq_request", got.irq_request, want.irq_request);
        checked_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timer_on   = 1'b0;
            clk_src    = '0;
            prescale_q = '0;
            compare_q  = '0;
            restart_q  = 1'b0;
            irq_en_q   = 1'b0;
            count_q    = '0;
            frac_q     = 0;
            event_q    = 1'b0;
            expected_readings.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_setting(i_cfg_index, i_cfg_data);
            // Results always come after their item is accepted, so check before predicting.
            if (i_out_valid && i_out_ready) check_reading(i_out);
            if (i_in_valid && i_in_ready) expected_readings.push_back(predict_timer_step(i_in));
        end
        pending_count = expected_readings.size();
    end

endmodule

/* sim/testbench.sv */
// Stimulus and verdict for the prescaled reference timer, with the checker beside the block.
module testbench;
    import prt_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [1:0] SRC_STOP     = 2'd0;
    localparam logic [1:0] SRC_STOP_ALT = 2'd3;
    localparam int         RUN_SETTINGS = 13;
    localparam int         ITEMS_EACH   = 100;

    typedef struct {
        logic        en;
        logic [1:0]  src;
        logic [7:0]  pre;
        logic [15:0] compare;
        logic        restart;
        logic        irq;
    } t_timer_setting;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in                   in_beat = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_beat;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int errors, pending, checked, ref_hits;
    int send_gap_pct = 21;
    int recv_stall_pct = 64;
    int items_sent = 0;
    int settings_used = 0;

    always #1 clk = ~clk;

    prescaled_reference_timer_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    timer_reading_checker result_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_matches   (ref_hits)
    );

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(input logic [1:0] kind, input logic [15:0] cycles,
                             input logic clear);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat.kind <= kind;
        in_beat.cycles_elapsed <= cycles;
        in_beat.clear_ref <= clear;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Lowers the item valid and waits until every predicted result has come back.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input t_timer_setting s);
        drain();
        write_register(CFG_TIMER_ENABLE, CFG_DATA_W'(s.en));
        write_register(CFG_CLOCK_SOURCE, CFG_DATA_W'(s.src));
        write_register(CFG_PRESCALE, CFG_DATA_W'(s.pre));
        write_register(CFG_REFERENCE, s.compare);
        write_register(CFG_RESTART, CFG_DATA_W'(s.restart));
        write_register(CFG_REF_IRQ_ENABLE, CFG_DATA_W'(s.irq));
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic t_timer_setting random_setting();
        t_timer_setting s;
        int unsigned pick;
        s.en = ($urandom_range(9) != 0);
        pick = $urandom_range(9);
        s.src = (pick == 0) ? SRC_STOP : (pick == 1) ? SRC_STOP_ALT :
                (pick < 6) ? SRC_SYS : SRC_SYS_DIV16;
        case ($urandom_range(3))
            0: s.pre = 8'd0;
            1: s.pre = 8'hFF;
            2: s.pre = 8'($urandom_range(7));
            default: s.pre = 8'($urandom);
        endcase
        case ($urandom_range(3))
            0: s.compare = 16'($urandom_range(1)) ? 16'hFFFF : 16'd0;
            1: s.compare = 16'($urandom_range(300));
            2: s.compare = 16'($urandom_range(8000));
            default: s.compare = 16'($urandom);
        endcase
        s.restart = 1'($urandom_range(1));
        s.irq = 1'($urandom_range(1));
        return s;
    endfunction

    // Mostly advances, with a spread of cycle counts around the current divider.
    task automatic send_random_item(input int unsigned divisor);
        logic [1:0] kind;
        logic [15:0] cycles;
        int unsigned pick, span;
        pick = $urandom_range(99);
        kind = (pick < 70) ? KIND_ADVANCE : (pick < 78) ? KIND_COUNTER_WR :
               (pick < 95) ? KIND_EVENT_WR : KIND_UNUSED;
        span = (divisor * 3 > 65535) ? 65535 : divisor * 3;
        case ($urandom_range(3))
            0: cycles = 16'($urandom_range(span));
            1: cycles = 16'($urandom);
            2: cycles = 16'($urandom_range(255));
            default: cycles = 16'hFFFF - 16'($urandom_range(15));
        endcase
        send_item(kind, cycles, 1'($urandom_range(1)));
    endtask

    initial begin
        t_timer_setting s;
        int unsigned divisor;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Registers hold their reset values first: the timer is off.
        send_item(KIND_ADVANCE, 16'hFFFF, 1'b0);
        send_item(KIND_UNUSED, 16'h0000, 1'b1);
        send_item(KIND_EVENT_WR, 16'h0000, 1'b0);
        apply_settings('{1'b1, SRC_STOP_ALT, 8'd0, 16'd0, 1'b0, 1'b0});
        send_item(KIND_ADVANCE, 16'd500, 1'b0);
        apply_settings('{1'b1, SRC_STOP, 8'd0, 16'd0, 1'b0, 1'b0});
        send_item(KIND_ADVANCE, 16'd500, 1'b0);
        apply_settings('{1'b1, SRC_SYS, 8'd0, 16'hFFFF, 1'b0, 1'b1});
        send_item(KIND_ADVANCE, 16'hFFFF, 1'b0);
        send_item(KIND_ADVANCE, 16'd1, 1'b0);
        send_item(KIND_EVENT_WR, 16'd0, 1'b1);
        send_item(KIND_ADVANCE, 16'hFFFF, 1'b0);
        send_item(KIND_COUNTER_WR, 16'hFFFF, 1'b1);
        send_item(KIND_ADVANCE, 16'd0, 1'b0);
        apply_settings('{1'b1, SRC_SYS_DIV16, 8'hFF, 16'd0, 1'b1, 1'b0});
        send_item(KIND_ADVANCE, 16'd4095, 1'b0);
        send_item(KIND_ADVANCE, 16'd1, 1'b0);
        send_item(KIND_ADVANCE, 16'hFFFF, 1'b0);
        send_item(KIND_EVENT_WR, 16'd0, 1'b1);
        // Leave the counter far above a small period, then switch to restart mode.
        apply_settings('{1'b1, SRC_SYS, 8'd0, 16'd1000, 1'b0, 1'b1});
        send_item(KIND_ADVANCE, 16'd60000, 1'b0);
        apply_settings('{1'b1, SRC_SYS, 8'd0, 16'd1000, 1'b1, 1'b1});
        send_item(KIND_ADVANCE, 16'd1, 1'b0);
        // The fraction must survive a stopped interval.
        apply_settings('{1'b1, SRC_SYS, 8'd9, 16'd1000, 1'b1, 1'b1});
        send_item(KIND_COUNTER_WR, 16'd0, 1'b0);
        send_item(KIND_ADVANCE, 16'd7, 1'b0);
        apply_settings('{1'b0, SRC_SYS, 8'd9, 16'd1000, 1'b1, 1'b1});
        send_item(KIND_ADVANCE, 16'd100, 1'b0);
        apply_settings('{1'b1, SRC_SYS, 8'd9, 16'd1000, 1'b1, 1'b1});
        send_item(KIND_ADVANCE, 16'd3, 1'b0);

        for (int k = 0; k < RUN_SETTINGS; k++) begin
            if (k == 5) begin
                send_gap_pct = 64;
                recv_stall_pct = 21;
            end else if (k == 9) begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            s = random_setting();
            apply_settings(s);
            divisor = (int'(s.pre) + 1) * ((s.src == SRC_SYS_DIV16) ? 16 : 1);
            for (int n = 0; n < ITEMS_EACH; n++) send_random_item(divisor);
        end

        drain();
        // Room for the longest item, so a stray result beat would still be seen.
        repeat (60) @(negedge clk);
        $display("Sent %0d input beats under %0d timer settings; checked %0d results.",
                 items_sent, settings_used, checked);
        $display("Reference matches predicted along the way: %0d.", ref_hits);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("Run timed out with %0d results outstanding.", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* prescaled_reference_timer_unit.f */
hdl/prt_pkg.sv
hdl/prt_div.sv
hdl/prt_dp.sv
hdl/prt_ctrl.sv
hdl/prescaled_reference_timer_unit.sv
sim/timer_reading_checker.sv
sim/testbench.sv
